[sv/ptg_pkg.sv]
// ----------------------------------------------------------------------------
// ptg_pkg: shared types and constants for the printable text generator
// Holds the generator constants, the character mapping constants, the
// register indexes and the item structs passed between pipeline stages.
// ----------------------------------------------------------------------------
package ptg_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LW_W       = 7;
  localparam int unsigned CHAR_W     = 7;

  localparam logic [63:0] DEFAULT_SEED = 64'h1234_5678_ABCD_EF01;
  localparam logic [63:0] MIX_MULT     = 64'h2545_F491_4F6C_DD1D;

  localparam int unsigned SHIFT_A = 12;
  localparam int unsigned SHIFT_B = 25;
  localparam int unsigned SHIFT_C = 27;

  localparam logic [7:0]        CHAR_BASE        = 8'h20;
  localparam logic [7:0]        CHAR_SPAN        = 8'd95;
  localparam logic [7:0]        CHAR_SPAN2       = 8'd190;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR     = 7'd10;
  localparam logic [CHAR_W-1:0] PRINT_LOW        = 7'd32;
  localparam logic [CHAR_W-1:0] PRINT_HIGH       = 7'd126;
  localparam logic [LW_W-1:0]   LINE_WIDTH_RESET = 7'd76;

  // byte index into the pending word; BYTE_EMPTY means all bytes spent
  localparam logic [3:0] BYTE_FIRST = 4'd0;
  localparam logic [3:0] BYTE_EMPTY = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED       = 1'b0,
    REG_LINE_WIDTH = 1'b1
  } cfg_reg_e;

  // item leaving the control stage
  typedef struct packed {
    logic        nl;
    logic        refill;
    logic [3:0]  idx;
    logic [63:0] gen;
  } ctl_item_t;

  // per-item tag that travels beside the product pipeline
  typedef struct packed {
    logic       nl;
    logic       refill;
    logic [3:0] idx;
  } tag_t;

  // one xorshift64 step
  function automatic logic [63:0] xorshift(input logic [63:0] s_in);
    logic [63:0] s;
    s = s_in;
    s = s ^ (s >> SHIFT_A);
    s = s ^ (s << SHIFT_B);
    s = s ^ (s >> SHIFT_C);
    return s;
  endfunction

endpackage

[sv/ptg_intf.sv]
// ----------------------------------------------------------------------------
// ptg_intf: channel interfaces of the printable text generator
// Request channel, character channel and register write channel, each with
// valid, ready and payload, and a source and a sink modport.
// ----------------------------------------------------------------------------
interface ptg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface ptg_out_if import ptg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              is_newline;

  modport source (output valid, output out_char, output is_newline, input ready);
  modport sink (input valid, input out_char, input is_newline, output ready);
endinterface

interface ptg_cfg_if import ptg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/ptg_ctrl.sv]
// ----------------------------------------------------------------------------
// ptg_ctrl: request control stage
// Holds the registers, the generator state, the column and position counts
// and the pending byte pointer; decides newline or refill for each request.
// ----------------------------------------------------------------------------
module ptg_ctrl import ptg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptg_in_if.sink    req_i,
  ptg_cfg_if.sink   cfg_i,
  output logic      item_valid_o,
  input  logic      item_ready_i,
  output ctl_item_t item_o
);

  logic [63:0]     seed_q;
  logic [LW_W-1:0] line_width_q;
  logic [63:0]     gen_q, gen_d;
  logic [LW_W-1:0] col_q, col_d;
  logic [2:0]      pos_q, pos_d;
  logic [3:0]      ptr_q, ptr_d;
  logic            s1_v_q;
  ctl_item_t       s1_q, s1_d;
  logic            accept;

  logic [63:0]     gen_cur;
  logic [LW_W-1:0] col_cur;
  logic [2:0]      pos_cur;
  logic [3:0]      ptr_cur;
  logic [63:0]     gen_adv;

  assign req_i.ready  = !s1_v_q || item_ready_i;
  assign accept       = req_i.valid && req_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign item_valid_o = s1_v_q;
  assign item_o       = s1_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q       <= '0;
      line_width_q <= LINE_WIDTH_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SEED:       seed_q       <= cfg_i.data;
        REG_LINE_WIDTH: line_width_q <= cfg_i.data[LW_W-1:0];
        default:        seed_q       <= seed_q;
      endcase
    end
  end

  // apply restart, then pick newline, refill or next pending byte
  always_comb begin
    gen_cur = req_i.restart ? ((seed_q != '0) ? seed_q : DEFAULT_SEED) : gen_q;
    col_cur = req_i.restart ? '0 : col_q;
    pos_cur = req_i.restart ? '0 : pos_q;
    ptr_cur = req_i.restart ? BYTE_EMPTY : ptr_q;
    gen_adv = xorshift(gen_cur);

    gen_d       = gen_cur;
    col_d       = col_cur;
    ptr_d       = ptr_cur;
    pos_d       = 3'(pos_cur + 3'd1);
    s1_d.nl     = 1'b0;
    s1_d.refill = 1'b0;
    s1_d.idx    = ptr_cur;
    s1_d.gen    = gen_adv;

    if (col_cur >= line_width_q) begin
      s1_d.nl = 1'b1;
      col_d   = '0;
    end else begin
      col_d = LW_W'(col_cur + 7'd1);
      if (pos_cur == 3'd0) begin
        gen_d       = gen_adv;
        s1_d.refill = 1'b1;
        s1_d.idx    = BYTE_FIRST;
        ptr_d       = 4'(BYTE_FIRST + 4'd1);
      end else if (ptr_cur != BYTE_EMPTY) begin
        ptr_d = 4'(ptr_cur + 4'd1);
      end
    end
  end

  // update control state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= DEFAULT_SEED;
      col_q <= '0;
      pos_q <= '0;
      ptr_q <= BYTE_EMPTY;
    end else if (accept) begin
      gen_q <= gen_d;
      col_q <= col_d;
      pos_q <= pos_d;
      ptr_q <= ptr_d;
    end
  end

  // stage register toward the product pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= BYTE_EMPTY)
    else $error("pending byte pointer beyond the word");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !req_i.restart |=> pos_q == 3'($past(pos_q) + 3'd1))
    else $error("position did not advance by one");

  a_restart_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.restart |=> pos_q == 3'd1)
    else $error("restart did not clear the position");

  a_refill_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s1_q.refill |-> !s1_q.nl && s1_q.idx == BYTE_FIRST)
    else $error("refill item not on the first byte");

endmodule

[sv/ptg_mix.sv]
// ----------------------------------------------------------------------------
// ptg_mix: xorshift64* output multiply
// Forms the low 64 bits of state times the mix constant from three 32x32
// partial products, sums them in the next stage and keeps the last product.
// ----------------------------------------------------------------------------
module ptg_mix import ptg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  ctl_item_t   item_i,
  output logic        tag_valid_o,
  input  logic        tag_ready_i,
  output tag_t        tag_o,
  output logic [63:0] prod_o
);

  localparam logic [31:0] MultLo = MIX_MULT[31:0];
  localparam logic [31:0] MultHi = MIX_MULT[63:32];

  logic        v2_q, v3_q;
  logic        rdy2, rdy3;
  tag_t        tag2_q, tag3_q;
  logic [63:0] p_ll_q;
  logic [31:0] p_lh_q, p_hl_q;
  logic [63:0] p_ll_d, p_lh_w, p_hl_w;
  logic [63:0] prod_q, prod_d;

  assign rdy3         = !v3_q || tag_ready_i;
  assign rdy2         = !v2_q || rdy3;
  assign item_ready_o = rdy2;
  assign tag_valid_o  = v3_q;
  assign tag_o        = tag3_q;
  assign prod_o       = prod_q;

  // partial products; high-by-high falls outside 64 bits
  always_comb begin
    p_ll_d = 64'(item_i.gen[31:0])  * 64'(MultLo);
    p_lh_w = 64'(item_i.gen[31:0])  * 64'(MultHi);
    p_hl_w = 64'(item_i.gen[63:32]) * 64'(MultLo);
    prod_d = p_ll_q + {32'(p_lh_q + p_hl_q), 32'b0};
  end

  // valid bits of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= item_valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // payload; hold the product of the latest refill for later bytes
  always_ff @(posedge clk_i) begin
    if (rdy2 && item_valid_i) begin
      tag2_q <= '{nl: item_i.nl, refill: item_i.refill, idx: item_i.idx};
      p_ll_q <= p_ll_d;
      p_lh_q <= p_lh_w[31:0];
      p_hl_q <= p_hl_w[31:0];
    end
    if (rdy3 && v2_q) begin
      tag3_q <= tag2_q;
      if (tag2_q.refill) begin
        prod_q <= prod_d;
      end
    end
  end

  a_tag_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy3 && v2_q |=> v3_q && tag3_q == $past(tag2_q))
    else $error("tag lost between product stages");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !tag_ready_i |=> v3_q && $stable(tag3_q) && $stable(prod_q))
    else $error("stalled product stage changed");

  a_refill_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy3 && v2_q && tag2_q.refill |=> prod_q == $past(prod_d))
    else $error("refill product not captured");

endmodule

[sv/ptg_emit.sv]
// ----------------------------------------------------------------------------
// ptg_emit: character mapping and result register
// Picks the byte of the pending word, maps it to printable ASCII or emits
// the newline, and holds the character until the sink takes it.
// ----------------------------------------------------------------------------
module ptg_emit import ptg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tag_valid_i,
  output logic        tag_ready_o,
  input  tag_t        tag_i,
  input  logic [63:0] prod_i,
  ptg_out_if.source   res_o
);

  logic              out_v_q;
  logic [CHAR_W-1:0] out_char_q, char_d;
  logic              out_nl_q;
  logic [7:0]        byte_w, rem_w, sum_w;

  assign tag_ready_o      = !out_v_q || res_o.ready;
  assign res_o.valid      = out_v_q;
  assign res_o.out_char   = out_char_q;
  assign res_o.is_newline = out_nl_q;

  // byte select, reduce modulo 95 by a single subtraction of 95 or 190, add base
  always_comb begin
    byte_w = (tag_i.idx == BYTE_EMPTY) ? 8'd0 : prod_i[{tag_i.idx[2:0], 3'b000} +: 8];
    if (byte_w >= CHAR_SPAN2) begin
      rem_w = 8'(byte_w - CHAR_SPAN2);
    end else if (byte_w >= CHAR_SPAN) begin
      rem_w = 8'(byte_w - CHAR_SPAN);
    end else begin
      rem_w = byte_w;
    end
    sum_w  = 8'(rem_w + CHAR_BASE);
    char_d = tag_i.nl ? NEWLINE_CHAR : sum_w[CHAR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (tag_ready_o) begin
      out_v_q <= tag_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_ready_o && tag_valid_i) begin
      out_char_q <= char_d;
      out_nl_q   <= tag_i.nl;
    end
  end

  a_nl_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_nl_q |-> out_char_q == NEWLINE_CHAR)
    else $error("newline flag without newline character");

  a_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_nl_q |-> out_char_q >= PRINT_LOW && out_char_q <= PRINT_HIGH)
    else $error("character outside printable range");

  a_nl_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_ready_o && tag_valid_i |=> out_v_q && out_nl_q == $past(tag_i.nl))
    else $error("newline flag not carried to the result");

endmodule

[sv/printable_text_generator_core.sv]
// ----------------------------------------------------------------------------
// printable_text_generator_core: pseudo-random printable text source
// Each request transfer yields one character transfer, in order. The core
// takes one request per cycle and delivers one character per cycle while the
// character side does not stall. A character passes through the control stage,
// partial product stage, product sum stage and result register, a depth set
// by the 64-bit xorshift64* multiply, which is split into three 32x32 partial
// products and a separate summing stage. Stalls on the character side back
// up only as far as stages are full. A request with restart set reloads the
// generator from the seed register (zero selects a built-in seed) and
// clears the column, position and pending word before its character. After
// line_width printable characters a newline is emitted. Register writes
// (seed at index 0, line_width at index 1) are taken at any time but should
// only be issued while no request is in flight.
// ----------------------------------------------------------------------------
module printable_text_generator_core import ptg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptg_in_if.sink    in_i,
  ptg_cfg_if.sink   cfg_i,
  ptg_out_if.source out_o
);

  logic        item_valid, item_ready;
  ctl_item_t   item;
  logic        tag_valid, tag_ready;
  tag_t        tag;
  logic [63:0] prod;

  // control stage: registers, counters and generator state
  ptg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (in_i),
    .cfg_i        (cfg_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // product pipeline
  ptg_mix u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .tag_valid_o  (tag_valid),
    .tag_ready_i  (tag_ready),
    .tag_o        (tag),
    .prod_o       (prod)
  );

  // character mapping and result register
  ptg_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_valid_i (tag_valid),
    .tag_ready_o (tag_ready),
    .tag_i       (tag),
    .prod_i      (prod),
    .res_o       (out_o)
  );

endmodule
